### hw/rtl/fifo_page_replacement_top_macros.svh
// Assertion macros shared by the page replacement checker.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef FIFO_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define FIFO_PAGE_REPLACEMENT_TOP_MACROS_SVH

// Same-cycle implication, masked during reset
`define FPR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpr: same-cycle check failed");

// Next-cycle implication, masked during reset
`define FPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpr: next-cycle check failed");

`endif

### hw/rtl/fpr_pkg.sv
// Shared types and constants for the FIFO page replacement block.
// No dependencies; used by fpr_cell, the top level and the checker.
`default_nettype none

package fpr_pkg;

    // Frame count register
    localparam int              CFG_W     = 4;
    localparam logic [CFG_W-1:0] FIU_RESET = 4'd8;

    // Saturating totals
    localparam int               CNT_W   = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Per-cell status handed back to the control logic
    typedef struct packed {
        logic hit;       // token found a matching resident page here
        logic miss_end;  // token reached the last active frame without a match
    } fpr_cell_stat_t;

    // Slot index width for a given frame count (at least one bit)
    function automatic int slot_bits(input int frames);
        return (frames > 1) ? $clog2(frames) : 1;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/fpr_cell.sv
// One frame cell: holds a resident page and its valid bit, checks the
// passing search token against it. Depends on fpr_pkg.
`default_nettype none

module fpr_cell #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16,
    parameter int IDX       = 0,
    localparam int SLOT_W   = fpr_pkg::slot_bits(FRAMES)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  tok_in,
    input  wire logic [PAGE_BITS-1:0]  page,
    input  wire logic [SLOT_W-1:0]     last_idx,
    input  wire logic                  wr_en,
    output logic                       tok_out,
    output fpr_pkg::fpr_cell_stat_t    stat
);
    import fpr_pkg::*;

    logic                 tok_reg;
    logic                 valid_reg;
    logic                 valid_next;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 match;
    logic                 at_last;

    // Compare and hand-off
    assign match   = tok_reg && valid_reg && (page_reg == page);
    assign at_last = (SLOT_W'(IDX) == last_idx);
    assign tok_out = tok_reg && !match && !at_last;

    always_comb
    begin
        stat.hit      = match;
        stat.miss_end = tok_reg && !match && at_last;
    end

    assign valid_next = valid_reg || wr_en;

    // Token and valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            tok_reg   <= tok_in;
            valid_reg <= valid_next;
        end
    end

    // Page storage, written on replacement
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            page_reg <= page;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fifo_page_replacement_top.sv
// Top level of the FIFO page replacement block: request control, replace
// pointer, totals and the row of fpr_cell frames. Depends on fpr_pkg.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  request   | start / busy         | page_number
//  result    | done (1-cycle strobe)| hit, frame_slot, fault_total, request_total
//  config    | cfg_wr_en            | frames_in_use
//
// A request is taken when start is high and busy low. A search token walks
// the cell row one frame per cycle from slot 0 and stops at the first hit or
// at the last active frame; that outcome is registered into done and the
// result, and busy stays high until the done cycle.
// Reset clears valid bits, pointer and totals and sets the frame count to 8.
// Results cannot be stalled; done is high for exactly one cycle.
`default_nettype none

module fifo_page_replacement_top #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16,
    localparam int SLOT_W   = fpr_pkg::slot_bits(FRAMES)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [PAGE_BITS-1:0]         page_number,
    input  wire logic                         cfg_wr_en,
    input  wire logic [fpr_pkg::CFG_W-1:0]    frames_in_use,
    output logic                              done,
    output logic                              hit,
    output logic [SLOT_W-1:0]                 frame_slot,
    output logic [fpr_pkg::CNT_W-1:0]         fault_total,
    output logic [fpr_pkg::CNT_W-1:0]         request_total
);
    import fpr_pkg::*;

    logic                 busy_reg,      busy_next;
    logic                 done_reg,      done_next;
    logic                 hit_reg;
    logic [SLOT_W-1:0]    slot_reg,      slot_next;
    logic [CNT_W-1:0]     fault_cnt_reg, fault_cnt_next;
    logic [CNT_W-1:0]     req_cnt_reg,   req_cnt_next;
    logic [SLOT_W-1:0]    ptr_reg,       ptr_next;
    logic [SLOT_W-1:0]    last_idx_reg,  last_idx_next;
    logic [CFG_W-1:0]     fiu_reg,       fiu_next;
    logic [PAGE_BITS-1:0] req_page_reg;

    logic                 accept;
    logic                 any_hit;
    logic                 any_miss;
    logic [SLOT_W-1:0]    hit_idx;
    logic [SLOT_W-1:0]    place;

    logic                 tok_link [FRAMES];
    logic                 wr_vec   [FRAMES];
    fpr_cell_stat_t       cell_stat[FRAMES];

    assign accept = start && !busy_reg;

    // Effective last frame index: frame count clamped into 1..FRAMES
    always_comb
    begin
        if (fiu_reg == '0)
            last_idx_next = '0;
        else if (int'(fiu_reg) > FRAMES)
            last_idx_next = SLOT_W'(FRAMES - 1);
        else
            last_idx_next = SLOT_W'(fiu_reg - 1'b1);
    end

    // Cell row
    assign tok_link[0] = accept;

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        assign wr_vec[i] = any_miss && (place == SLOT_W'(i));

        if (i < FRAMES - 1)
        begin : g_mid
            fpr_cell #(
                .FRAMES    (FRAMES),
                .PAGE_BITS (PAGE_BITS),
                .IDX       (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .tok_in   (tok_link[i]),
                .page     (req_page_reg),
                .last_idx (last_idx_reg),
                .wr_en    (wr_vec[i]),
                .tok_out  (tok_link[i+1]),
                .stat     (cell_stat[i])
            );
        end
        else
        begin : g_end
            fpr_cell #(
                .FRAMES    (FRAMES),
                .PAGE_BITS (PAGE_BITS),
                .IDX       (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .tok_in   (tok_link[i]),
                .page     (req_page_reg),
                .last_idx (last_idx_reg),
                .wr_en    (wr_vec[i]),
                .tok_out  (),
                .stat     (cell_stat[i])
            );
        end
    end

    // Collect cell status; at most one cell holds the token
    always_comb
    begin
        any_hit  = 1'b0;
        any_miss = 1'b0;
        hit_idx  = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            any_hit  = any_hit  | cell_stat[i].hit;
            any_miss = any_miss | cell_stat[i].miss_end;
            hit_idx  = hit_idx  | (cell_stat[i].hit ? SLOT_W'(i) : '0);
        end
    end

    // Replacement slot: pointer beyond the active range falls back to slot 0
    assign place = (ptr_reg <= last_idx_reg) ? ptr_reg : '0;

    // Next-state logic
    always_comb
    begin
        busy_next      = busy_reg;
        done_next      = 1'b0;
        slot_next      = slot_reg;
        fault_cnt_next = fault_cnt_reg;
        req_cnt_next   = req_cnt_reg;
        ptr_next       = ptr_reg;
        fiu_next       = cfg_wr_en ? frames_in_use : fiu_reg;

        if (accept)
            busy_next = 1'b1;

        if (any_hit || any_miss)
        begin
            busy_next    = 1'b0;
            done_next    = 1'b1;
            req_cnt_next = (req_cnt_reg == CNT_MAX) ? req_cnt_reg : req_cnt_reg + 1'b1;
            slot_next    = any_hit ? hit_idx : place;
        end

        if (any_miss)
        begin
            ptr_next       = (place == last_idx_reg) ? '0 : place + 1'b1;
            fault_cnt_next = (fault_cnt_reg == CNT_MAX) ? fault_cnt_reg
                                                        : fault_cnt_reg + 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            fault_cnt_reg <= '0;
            req_cnt_reg   <= '0;
            ptr_reg       <= '0;
            fiu_reg       <= FIU_RESET;
        end
        else
        begin
            busy_reg      <= busy_next;
            done_reg      <= done_next;
            fault_cnt_reg <= fault_cnt_next;
            req_cnt_reg   <= req_cnt_next;
            ptr_reg       <= ptr_next;
            fiu_reg       <= fiu_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_page_reg <= page_number;
            last_idx_reg <= last_idx_next;
        end
        if (any_hit || any_miss)
        begin
            hit_reg <= any_hit;
        end
        slot_reg <= slot_next;
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign hit           = hit_reg;
    assign frame_slot    = slot_reg;
    assign fault_total   = fault_cnt_reg;
    assign request_total = req_cnt_reg;

endmodule

`default_nettype wire

### hw/rtl/fpr_checker.sv
// Port-level checks for the page replacement block, bound to the top level.
// Depends on fpr_pkg and fifo_page_replacement_top_macros.svh.
`default_nettype none

`include "fifo_page_replacement_top_macros.svh"

module fpr_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       done,
    input wire logic                       hit,
    input wire logic [fpr_pkg::CNT_W-1:0]  fault_total,
    input wire logic [fpr_pkg::CNT_W-1:0]  request_total
);
    import fpr_pkg::*;

    // An accepted request holds the block busy in the next cycle
    `FPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // A result ends the request: busy has dropped by the strobe
    `FPR_ASSERT_SAME(a_done_idle, done, !busy)

    // Each search passes a cell's token register before its result is registered, so strobes never sit back to back
    `FPR_ASSERT_NEXT(a_done_single, done, !done)

    // A hit leaves the fault total untouched
    `FPR_ASSERT_SAME(a_hit_no_fault, done && hit, fault_total == $past(fault_total))

    // Every result advances the request total unless it is saturated
    `FPR_ASSERT_SAME(a_req_count, done,
                     request_total != $past(request_total) || request_total == CNT_MAX)

endmodule

bind fifo_page_replacement_top fpr_checker u_fpr_checker (.*);

`default_nettype wire

### dv/fifo_page_replacement_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fifo_page_replacement_top: drives page requests in bursts,
// predicts hit/slot/totals in a scoreboard class and checks every done strobe.
// Depends on fpr_pkg and the fifo_page_replacement_top RTL.

module fifo_page_replacement_top_tb;

    import fpr_pkg::*;

    localparam int FRAMES    = 8;
    localparam int PAGE_W    = 16;
    localparam int SLOT_W    = slot_bits(FRAMES);
    localparam int RAND_PHASES      = 12;
    localparam int ITEMS_PER_PHASE  = 78;
    localparam int SETTLE_CYCLES    = 12;

    // One expected result
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  faults;
        logic [CNT_W-1:0]  requests;
    } page_result_t;

    // Predicts the FIFO replacement state and checks results in order
    class page_fifo_scoreboard;
        logic [PAGE_W-1:0] frame_page [FRAMES];
        logic              frame_valid [FRAMES];
        int unsigned       replace_ptr;
        logic [CNT_W-1:0]  fault_cnt;
        logic [CNT_W-1:0]  request_cnt;
        logic [CFG_W-1:0]  frame_limit;
        page_result_t      expected_q[$];
        int unsigned       errors;

        function new();
            foreach (frame_valid[k])
            begin
                frame_valid[k] = 1'b0;
                frame_page[k]  = '0;
            end
            replace_ptr = 0;
            fault_cnt   = '0;
            request_cnt = '0;
            frame_limit = FIU_RESET;
            errors      = 0;
        endfunction

        function void write_frame_limit(logic [CFG_W-1:0] v);
            frame_limit = v;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Accepted request: update the model and queue the expected result
        function void note_request(logic [PAGE_W-1:0] pg);
            int unsigned  n;
            int unsigned  k;
            int unsigned  put;
            page_result_t r;
            n = frame_limit;
            if (n < 1)
                n = 1;
            if (n > FRAMES)
                n = FRAMES;
            r = '0;
            // lowest matching valid slot among the active frames
            for (k = 0; k < n; k++)
            begin
                if (frame_valid[k] && frame_page[k] == pg)
                begin
                    r.hit  = 1'b1;
                    r.slot = SLOT_W'(k);
                    break;
                end
            end
            // fault: place at the replace pointer, slot 0 if it lies past the count
            if (!r.hit)
            begin
                put = (replace_ptr < n) ? replace_ptr : 0;
                frame_page[put]  = pg;
                frame_valid[put] = 1'b1;
                r.slot           = SLOT_W'(put);
                replace_ptr      = (put + 1 >= n) ? 0 : put + 1;
                if (fault_cnt != CNT_MAX)
                    fault_cnt++;
            end
            if (request_cnt != CNT_MAX)
                request_cnt++;
            r.faults   = fault_cnt;
            r.requests = request_cnt;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [CNT_W-1:0] exp_v,
                                    logic [CNT_W-1:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(logic hit_v, logic [SLOT_W-1:0] slot_v,
                                   logic [CNT_W-1:0] faults_v,
                                   logic [CNT_W-1:0] requests_v);
            page_result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result expected none got hit=%0h slot=%0h",
                         $time, hit_v, slot_v);
                return;
            end
            e = expected_q.pop_front();
            compare_field("hit", CNT_W'(e.hit), CNT_W'(hit_v));
            compare_field("frame_slot", CNT_W'(e.slot), CNT_W'(slot_v));
            compare_field("fault_total", e.faults, faults_v);
            compare_field("request_total", e.requests, requests_v);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [PAGE_W-1:0]   page_number = '0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]    frames_in_use = FIU_RESET;
    logic                busy;
    logic                done;
    logic                hit;
    logic [SLOT_W-1:0]   frame_slot;
    logic [CNT_W-1:0]    fault_total;
    logic [CNT_W-1:0]    request_total;

    page_fifo_scoreboard sb = new();

    fifo_page_replacement_top #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .page_number   (page_number),
        .cfg_wr_en     (cfg_wr_en),
        .frames_in_use (frames_in_use),
        .done          (done),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .fault_total   (fault_total),
        .request_total (request_total)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Monitor: results, accepted requests and register writes, all at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(hit, frame_slot, fault_total, request_total);
            if (start && !busy)
                sb.note_request(page_number);
            if (cfg_wr_en)
                sb.write_frame_limit(frames_in_use);
        end
    end

    // Present one request and hold it until accepted
    task automatic issue_request(input logic [PAGE_W-1:0] pg);
        start       <= 1'b1;
        page_number <= pg;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start and wait until every expected result has arrived
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic set_frame_count(input logic [CFG_W-1:0] v);
        settle();
        cfg_wr_en     <= 1'b1;
        frames_in_use <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly pages from a small pool so hits and evictions both happen
    function automatic logic [PAGE_W-1:0] pick_page(logic [PAGE_W-1:0] base,
                                                    int unsigned pool);
        if ($urandom_range(0, 99) < 15)
            return PAGE_W'($urandom());
        return base ^ PAGE_W'($urandom_range(0, pool - 1));
    endfunction

    // Directed sequence, then random phases over several frame counts
    initial
    begin
        logic [PAGE_W-1:0] directed_a [14];
        logic [PAGE_W-1:0] base;
        logic [CFG_W-1:0]  fcount;
        int unsigned       n_eff;
        int unsigned       pool;
        int unsigned       left;
        int unsigned       burst;
        bit                steady;
        int                ph;
        int                k;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, hits, fill of all frames and wrap of the pointer (count 8)
        directed_a = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0102, 16'h0103,
                       16'h0104, 16'h0105, 16'h0106, 16'h0107, 16'h0107, 16'h5A5A,
                       16'h0000, 16'hA5A5};
        for (k = 0; k < 14; k++)
            issue_request(directed_a[k]);

        // pointer beyond the count, frames above the count ignored
        set_frame_count(CFG_W'(2));
        issue_request(16'h0105);
        issue_request(16'h0000);

        // same page resident twice: lowest slot wins
        set_frame_count(CFG_W'(8));
        issue_request(16'h0105);

        // zero acts as one frame
        set_frame_count(CFG_W'(0));
        issue_request(16'h3C3C);
        issue_request(16'h3C3C);
        issue_request(16'h0000);

        // above the frame count saturates to all frames
        set_frame_count(CFG_W'(15));
        issue_request(16'h0105);
        issue_request(16'h3C3C);

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:       fcount = CFG_W'(1);
                1:       fcount = CFG_W'(15);
                2:       fcount = CFG_W'(0);
                3:       fcount = CFG_W'(8);
                default: fcount = CFG_W'($urandom_range(0, 15));
            endcase
            set_frame_count(fcount);
            n_eff  = (fcount < 1) ? 1 : ((fcount > FRAMES) ? FRAMES : fcount);
            pool   = n_eff + $urandom_range(1, 4);
            base   = PAGE_W'($urandom());
            steady = ($urandom_range(0, 3) == 0);
            left   = ITEMS_PER_PHASE;
            while (left > 0)
            begin
                burst = $urandom_range(1, 16);
                if (burst > left)
                    burst = left;
                for (k = 0; k < burst; k++)
                    issue_request(pick_page(base, pool));
                left -= burst;
                // gap after some bursts; sometimes drain the block completely
                if (!steady && left > 0)
                begin
                    if ($urandom_range(0, 9) == 0)
                        settle();
                    else if ($urandom_range(0, 3) != 0)
                    begin
                        start <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(posedge clk);
                    end
                end
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // About 1000 requests fit far inside this limit
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
